// File: rtl/dpi_pkg.sv
// Shared types and fixed constants for the depth profile interpolator.
// Used by dpi_div and depth_profile_interpolator_core; depends on nothing.
package dpi_pkg;

    // Field widths fixed by the item format.
    localparam int VEL_W   = 16;
    localparam int DEPTH_W = 25;
    localparam int SPAN_W  = DEPTH_W + 1;
    localparam int DIFF_W  = VEL_W + 1;
    localparam int PROD_W  = SPAN_W + DIFF_W;

    // Shared divider: the quotient magnitude always stays below 2**DIV_Q_W.
    localparam int DIV_Q_W   = 17;
    localparam int DIV_DVS_W = DEPTH_W;
    localparam int DIV_DVD_W = DIV_DVS_W + DIV_Q_W;
    localparam int DIV_CNT_W = 5;

    // Item kinds.
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_GLOBAL = 2'd2;
    localparam logic [1:0] KIND_QUERY  = 2'd3;

    // Result source codes.
    localparam logic [1:0] SRC_SURFACE = 2'd0;
    localparam logic [1:0] SRC_GLOBAL  = 2'd1;
    localparam logic [1:0] SRC_CLAMP   = 2'd2;
    localparam logic [1:0] SRC_INTERP  = 2'd3;

    // One profile table entry; vel[0] is x, vel[1] is y, vel[2] is z.
    typedef struct packed {
        logic [DEPTH_W-1:0]       depth;
        logic [2:0][VEL_W-1:0]    vel;
    } dpi_entry_t;

    // Request into the shared divider.
    typedef struct packed {
        logic                 start;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DVS_W-1:0] divisor;
    } dpi_div_req_t;

    // Response from the shared divider.
    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quotient;
    } dpi_div_rsp_t;

endpackage

// File: rtl/dpi_div.sv
// Shared unsigned restoring divider, one quotient bit per cycle.
// Depends on dpi_pkg for widths and the request and response structs.
module dpi_div
    import dpi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  dpi_div_req_t req,
    output dpi_div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_DVS_W-1:0] rem_reg, rem_next;
    logic [DIV_DVS_W-1:0] dvs_reg, dvs_next;
    logic [DIV_Q_W-1:0]   dvd_reg, dvd_next;
    logic [DIV_Q_W-1:0]   quo_reg, quo_next;
    logic [DIV_DVS_W:0]   trial;
    logic                 fits;

    // The caller guarantees dividend < divisor * 2**DIV_Q_W, so the upper
    // part of the dividend is already a valid partial remainder.
    assign trial = {rem_reg, dvd_reg[DIV_Q_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    // One shift-and-subtract step per busy cycle.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_Q_W);
            rem_next  = req.dividend[DIV_DVD_W-1:DIV_Q_W];
            dvd_next  = req.dividend[DIV_Q_W-1:0];
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIV_DVS_W'(trial - {1'b0, dvs_reg}) : trial[DIV_DVS_W-1:0];
            dvd_next = {dvd_reg[DIV_Q_W-2:0], 1'b0};
            quo_next = {quo_reg[DIV_Q_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    // A new division is never started over one in flight.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    // The final step raises done and frees the unit.
    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !req.start && cnt_reg == DIV_CNT_W'(1)) |=> (done_reg && !busy_reg))
        else $error("divider did not finish after its last step");

    // Done only follows a busy cycle.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without work");

endmodule

// File: rtl/depth_profile_interpolator_core.sv
// Depth profile interpolator: ascending depth table with velocity lookup.
// A negative depth gives zero velocity and an empty table gives the global velocity; a query at or beyond
// an endpoint is clamped to that entry, and any other query is interpolated:
// one table read per walk step, then per axis one multiply and one divider run.
// A point marked last, with no global velocity given, holds the input while the three averages
// are formed. Reset empties the table and zeroes sums and global velocity.
module depth_profile_interpolator_core
    import dpi_pkg::*;
#(
    parameter int NPOINTS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                kind,
    input  logic signed [DEPTH_W-1:0] depth_mm,
    input  logic signed [VEL_W-1:0]   vel_x,
    input  logic signed [VEL_W-1:0]   vel_y,
    input  logic signed [VEL_W-1:0]   vel_z,
    input  logic                      last_point,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [VEL_W-1:0]   cur_x,
    output logic signed [VEL_W-1:0]   cur_y,
    output logic signed [VEL_W-1:0]   cur_z,
    output logic [1:0]                source
);

    localparam int IDX_W   = $clog2(NPOINTS);
    localparam int CNT_W   = $clog2(NPOINTS + 1);
    localparam int SUM_W   = VEL_W + $clog2(NPOINTS);
    localparam int STATE_W = 3;

    // Sequencer states.
    localparam logic [STATE_W-1:0] S_IDLE  = 3'd0;
    localparam logic [STATE_W-1:0] S_FIRST = 3'd1;
    localparam logic [STATE_W-1:0] S_LAST  = 3'd2;
    localparam logic [STATE_W-1:0] S_WALK  = 3'd3;
    localparam logic [STATE_W-1:0] S_SPAN  = 3'd4;
    localparam logic [STATE_W-1:0] S_MUL   = 3'd5;
    localparam logic [STATE_W-1:0] S_DIV   = 3'd6;
    localparam logic [STATE_W-1:0] S_WAIT  = 3'd7;

    // Saturate an interpolated value to the velocity range.
    function automatic logic [VEL_W-1:0] sat_vel(input logic signed [VEL_W+1:0] v);
        logic [VEL_W-1:0] r;
        if (v > (VEL_W+2)'(32767))
            r = 16'h7FFF;
        else if (v < -(VEL_W+2)'(32768))
            r = 16'h8000;
        else
            r = v[VEL_W-1:0];
        return r;
    endfunction

    // Control state.
    logic [STATE_W-1:0]       state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic signed [SUM_W-1:0]  sum_reg [3];
    logic signed [SUM_W-1:0]  sum_next [3];
    logic [2:0][VEL_W-1:0]    glob_reg, glob_next;
    logic                     explicit_reg, explicit_next;
    logic                     out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [1:0]               axis_reg, axis_next;
    logic                     avg_reg, avg_next;

    // Payload state.
    logic signed [DEPTH_W-1:0] q_depth_reg, q_depth_next;
    dpi_entry_t                lo_ent_reg, lo_ent_next;
    dpi_entry_t                hi_ent_reg, hi_ent_next;
    logic signed [SPAN_W-1:0]  span_reg, span_next;
    logic signed [SPAN_W-1:0]  off_reg, off_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [2:0][VEL_W-1:0]     res_reg, res_next;
    logic [1:0]                src_reg, src_next;

    // Table memory.
    dpi_entry_t                mem [NPOINTS];
    dpi_entry_t                rd_data_reg;
    dpi_entry_t                wr_ent;
    logic                      mem_we;
    logic [IDX_W-1:0]          rd_addr;

    // Datapath helpers.
    logic                      in_fire;
    logic                      out_fire;
    logic [2:0][VEL_W-1:0]     in_vel;
    logic signed [DEPTH_W-1:0] rd_depth;
    logic signed [SPAN_W-1:0]  span_c;
    logic signed [SPAN_W-1:0]  off_c;
    logic signed [DIFF_W-1:0]  diff_c;
    logic signed [PROD_W-1:0]  prod_c;
    logic signed [SUM_W-1:0]   sum_sel;
    logic [SUM_W-1:0]          sum_abs;
    logic [PROD_W-1:0]         prod_abs;
    logic                      quo_neg;
    logic signed [VEL_W+1:0]   quo_s;
    logic signed [VEL_W+1:0]   interp_c;
    logic                      div_start;
    dpi_div_req_t              div_req;
    dpi_div_rsp_t              div_rsp;

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign in_vel   = {vel_z, vel_y, vel_x};
    assign rd_depth = $signed(rd_data_reg.depth);
    assign wr_ent   = '{depth: depth_mm, vel: in_vel};

    // Span and offset of the bracket; the offset is positive by construction.
    assign span_c = SPAN_W'($signed(hi_ent_reg.depth)) - SPAN_W'($signed(lo_ent_reg.depth));
    assign off_c  = SPAN_W'(q_depth_reg) - SPAN_W'($signed(lo_ent_reg.depth));
    assign diff_c = DIFF_W'($signed(hi_ent_reg.vel[axis_reg]))
                  - DIFF_W'($signed(lo_ent_reg.vel[axis_reg]));
    assign prod_c = off_reg * diff_c;

    // Divider operands: magnitudes, with the sign applied after division.
    assign sum_sel  = sum_reg[axis_reg];
    assign sum_abs  = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
    assign prod_abs = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign quo_neg  = avg_reg ? sum_sel[SUM_W-1] : prod_reg[PROD_W-1];
    assign quo_s    = quo_neg ? -$signed({1'b0, div_rsp.quotient})
                              : $signed({1'b0, div_rsp.quotient});
    assign interp_c = (VEL_W+2)'($signed(lo_ent_reg.vel[axis_reg])) + quo_s;

    assign div_req.start    = div_start;
    assign div_req.dividend = avg_reg ? DIV_DVD_W'(sum_abs) : prod_abs[DIV_DVD_W-1:0];
    assign div_req.divisor  = avg_reg ? DIV_DVS_W'(count_reg) : span_reg[DIV_DVS_W-1:0];

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        glob_next      = glob_reg;
        explicit_next  = explicit_reg;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        axis_next      = axis_reg;
        avg_next       = avg_reg;
        q_depth_next   = q_depth_reg;
        lo_ent_next    = lo_ent_reg;
        hi_ent_next    = hi_ent_reg;
        span_next      = span_reg;
        off_next       = off_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        src_next       = src_reg;
        mem_we         = 1'b0;
        rd_addr        = '0;
        div_start      = 1'b0;

        if (out_fire)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (kind)
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                            for (int k = 0; k < 3; k++)
                                sum_next[k] = '0;
                        end
                        KIND_APPEND:
                        begin
                            // A full table drops the point but still honors the last mark.
                            if (count_reg < CNT_W'(NPOINTS))
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                for (int k = 0; k < 3; k++)
                                    sum_next[k] = sum_reg[k] + SUM_W'($signed(in_vel[k]));
                            end
                            if (last_point && !explicit_reg && count_next != '0)
                            begin
                                avg_next   = 1'b1;
                                axis_next  = 2'd0;
                                state_next = S_DIV;
                            end
                        end
                        KIND_GLOBAL:
                        begin
                            glob_next     = in_vel;
                            explicit_next = 1'b1;
                        end
                        default:
                        begin
                            q_depth_next = depth_mm;
                            if (depth_mm < 0)
                            begin
                                res_next       = '0;
                                src_next       = SRC_SURFACE;
                                out_valid_next = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                res_next       = glob_reg;
                                src_next       = SRC_GLOBAL;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_FIRST;
                            end
                        end
                    endcase
                end
            end
            S_FIRST:
            begin
                // Entry 0 is in the read register.
                lo_ent_next = rd_data_reg;
                if (q_depth_reg <= rd_depth)
                begin
                    res_next       = rd_data_reg.vel;
                    src_next       = SRC_CLAMP;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    rd_addr    = IDX_W'(count_reg - 1'b1);
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                // The last entry is in the read register.
                if (q_depth_reg >= rd_depth)
                begin
                    res_next       = rd_data_reg.vel;
                    src_next       = SRC_CLAMP;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    idx_next   = CNT_W'(1);
                    rd_addr    = IDX_W'(1);
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                // Entry idx is the candidate upper bracket; stop at the last pair.
                if ((idx_reg + 1'b1) < count_reg && q_depth_reg > rd_depth)
                begin
                    lo_ent_next = rd_data_reg;
                    idx_next    = idx_reg + 1'b1;
                    rd_addr     = IDX_W'(idx_reg + 1'b1);
                end
                else
                begin
                    hi_ent_next = rd_data_reg;
                    state_next  = S_SPAN;
                end
            end
            S_SPAN:
            begin
                span_next = span_c;
                off_next  = off_c;
                if (span_c <= 0)
                begin
                    res_next       = lo_ent_reg.vel;
                    src_next       = SRC_INTERP;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    avg_next   = 1'b0;
                    axis_next  = 2'd0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = prod_c;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                div_start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (avg_reg)
                        glob_next[axis_reg] = quo_s[VEL_W-1:0];
                    else
                        res_next[axis_reg] = sat_vel(interp_c);
                    if (axis_reg == 2'd2)
                    begin
                        if (!avg_reg)
                        begin
                            src_next       = SRC_INTERP;
                            out_valid_next = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = avg_reg ? S_DIV : S_MUL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sum_reg       <= '{default: '0};
            glob_reg      <= '0;
            explicit_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            axis_reg      <= '0;
            avg_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            glob_reg      <= glob_next;
            explicit_reg  <= explicit_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            axis_reg      <= axis_next;
            avg_reg       <= avg_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        q_depth_reg <= q_depth_next;
        lo_ent_reg  <= lo_ent_next;
        hi_ent_reg  <= hi_ent_next;
        span_reg    <= span_next;
        off_reg     <= off_next;
        prod_reg    <= prod_next;
        res_reg     <= res_next;
        src_reg     <= src_next;
    end

    // Table memory: one write port at the fill count, one registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[count_reg[IDX_W-1:0]] <= wr_ent;
        rd_data_reg <= mem[rd_addr];
    end

    // Shared divider for the averages and the interpolation quotients.
    dpi_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_valid = out_valid_reg;
    assign cur_x     = res_reg[0];
    assign cur_y     = res_reg[1];
    assign cur_z     = res_reg[2];
    assign source    = src_reg;

    // The fill count never passes the table size.
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(NPOINTS))
        else $error("point count beyond table size");

    // The bracket walk only reads filled entries past the first.
    a_walk_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (idx_reg < count_reg && idx_reg != '0))
        else $error("bracket walk outside the filled table");

    // A result waits only while the sequencer is idle.
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("result pending while sequencer busy");

    // Interpolation divides only by a positive span.
    a_span_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (span_reg > 0))
        else $error("interpolation with a non-positive span");

endmodule
